/* rtl/lsp_pkg.sv */
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants for the line steering PID
// Field widths, register indexes, reset values, and the product bundle
// passed from the multiplier stage.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int XW     = 16;   // one top column
    localparam int SUMW   = 17;   // sum of two columns (half pixels)
    localparam int ERRW   = 19;   // error
    localparam int DIFW   = 20;   // error difference
    localparam int ACCW   = 40;   // error accumulator
    localparam int GAINW  = 32;   // Q0.32 gains
    localparam int TCW    = 12;   // target column
    localparam int LIMW   = 14;   // outlier limit
    localparam int TURNW  = 32;   // Q16.16 turn rate
    localparam int ALW    = 20;   // low slice of the accumulator
    localparam int AHW    = ACCW - ALW;
    localparam int IDXW   = 3;    // register index width

    localparam int PHW    = GAINW + 1 + AHW;   // ki * high slice
    localparam int PLW    = GAINW + ALW;       // ki * low slice
    localparam int PEW    = GAINW + 1 + ERRW;  // kp * error
    localparam int PDW    = GAINW + 1 + DIFW;  // kd * difference

    localparam logic [TCW-1:0]   RST_TARGET_COLUMN = TCW'(325);
    localparam logic [LIMW-1:0]  RST_OUTLIER_LIMIT = LIMW'(1000);
    localparam logic [GAINW-1:0] RST_KP_GAIN       = GAINW'(6871948);
    localparam logic [GAINW-1:0] RST_KI_GAIN       = GAINW'(4724);
    localparam logic [GAINW-1:0] RST_KD_GAIN       = GAINW'(16106127);

    typedef enum logic [IDXW-1:0] {
        CFG_TARGET_COLUMN = 3'd0,
        CFG_OUTLIER_LIMIT = 3'd1,
        CFG_KP_GAIN       = 3'd2,
        CFG_KI_GAIN       = 3'd3,
        CFG_KD_GAIN       = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [TCW-1:0]   target_column;
        logic [LIMW-1:0]  outlier_limit;
        logic [GAINW-1:0] kp_gain;
        logic [GAINW-1:0] ki_gain;
        logic [GAINW-1:0] kd_gain;
    } t_cfg;

    typedef struct packed {
        logic signed [PHW-1:0] ph;   // ki * floor(acc / 2^20)
        logic        [PLW-1:0] pl;   // ki * (acc mod 2^20)
        logic signed [PEW-1:0] pe;   // kp * error
        logic signed [PDW-1:0] pd;   // kd * difference
    } t_prod;

endpackage

/* rtl/lsp_mult.sv */
// ----------------------------------------------------------------------------
// lsp_mult: registered gain products
// Four independent products of the PID terms, one register stage.
// ----------------------------------------------------------------------------
module lsp_mult import lsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  t_cfg                   i_cfg,
    input  logic signed [ACCW-1:0] i_acc,
    input  logic signed [ERRW-1:0] i_err,
    input  logic signed [DIFW-1:0] i_diff,
    output t_prod                  o_prod
);

    logic signed [AHW-1:0] acc_hi;
    logic        [ALW-1:0] acc_lo;
    t_prod                 n_prod;
    t_prod                 r_prod;

    // high slice is the floor of acc / 2^20, low slice the remainder
    assign acc_hi = i_acc[ACCW-1:ALW];
    assign acc_lo = i_acc[ALW-1:0];

    always_comb begin
        n_prod.ph = $signed({1'b0, i_cfg.ki_gain}) * acc_hi;
        n_prod.pl = i_cfg.ki_gain * acc_lo;
        n_prod.pe = $signed({1'b0, i_cfg.kp_gain}) * i_err;
        n_prod.pd = $signed({1'b0, i_cfg.kd_gain}) * i_diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

/* rtl/line_steer_pid.sv */
// ----------------------------------------------------------------------------
// line_steer_pid: steering turn rate from the top end points of two lines
// Outlier-filtered column sum feeds a saturating PID with Q0.32 gains; the
// negated result leaves as signed Q16.16 together with the sum used.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      content
//  --------  ---  -----------------------------  ------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready  top_x_first, top_x_second
//  m_axis    out  m_axis_tvalid / m_axis_tready  turn_rate, held_top_sum
//  cfg       in   i_cfg_valid / o_cfg_ready      register index, write data
//
//  One item per cycle sustained while m_axis_tready is high. The rate is set by
//  the state update stage: filter, error and accumulator settle within it, so
//  the next item sees the updated state. Each stage holds only while its
//  successor is full and stalled, so bubbles collapse and input keeps flowing
//  into empty stages while a result waits.
//  Synchronous active-low reset clears the stage valids, the PID state and
//  the registers to their defaults. Config writes are always accepted.
//
module line_steer_pid import lsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [15:0] top_x_first, [31:16] top_x_second
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata,   // [31:0] turn_rate, [48:32] held_top_sum
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDXW-1:0]   i_cfg_index,
    input  logic [GAINW-1:0]  i_cfg_data
);

    localparam logic signed [ACCW-1:0]  ACC_MAX  = {1'b0, {(ACCW-1){1'b1}}};
    localparam logic signed [ACCW-1:0]  ACC_MIN  = {1'b1, {(ACCW-1){1'b0}}};
    localparam logic signed [TURNW-1:0] TURN_MAX = {1'b0, {(TURNW-1){1'b1}}};
    localparam logic signed [TURNW-1:0] TURN_MIN = {1'b1, {(TURNW-1){1'b0}}};
    localparam logic signed [PHW-1:0]   IP_LIM   = PHW'(64'sd1 <<< 40);
    localparam int QW = 48;   // quotient after dropping 16 fraction bits

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_column <= RST_TARGET_COLUMN;
            r_cfg.outlier_limit <= RST_OUTLIER_LIMIT;
            r_cfg.kp_gain       <= RST_KP_GAIN;
            r_cfg.ki_gain       <= RST_KI_GAIN;
            r_cfg.kd_gain       <= RST_KD_GAIN;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_COLUMN: r_cfg.target_column <= i_cfg_data[TCW-1:0];
                CFG_OUTLIER_LIMIT: r_cfg.outlier_limit <= i_cfg_data[LIMW-1:0];
                CFG_KP_GAIN:       r_cfg.kp_gain       <= i_cfg_data;
                CFG_KI_GAIN:       r_cfg.ki_gain       <= i_cfg_data;
                CFG_KD_GAIN:       r_cfg.kd_gain       <= i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when empty or when its successor moves
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !r_v6 || m_axis_tready;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic signed [XW-1:0] r1_x1, r1_x2;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_x1 <= s_axis_tdata[15:0];
            r1_x2 <= s_axis_tdata[31:16];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: outlier filter, error, accumulator and difference
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0] r_good;     // last good sum
    logic signed [ERRW-1:0] r_prev_e;   // previous error
    logic signed [ACCW-1:0] r_acc;      // error accumulator
    logic signed [SUMW-1:0] n_good;
    logic signed [ERRW-1:0] n_prev_e;
    logic signed [ACCW-1:0] n_acc;
    logic signed [DIFW-1:0] n_diff;

    logic signed [SUMW-1:0] sum_raw, sum_use;
    logic        [SUMW-1:0] mag_raw, mag_use;
    logic        [LIMW:0]   lim2;
    logic signed [ACCW:0]   acc_wide;
    logic                   upd;

    assign upd  = en2 && r_v1;
    assign lim2 = {r_cfg.outlier_limit, 1'b0};

    always_comb begin
        sum_raw  = SUMW'(r1_x1) + SUMW'(r1_x2);
        mag_raw  = sum_raw[SUMW-1] ? SUMW'(-sum_raw) : sum_raw;
        // replace an outlier by the last good sum
        sum_use  = (mag_raw > SUMW'(lim2)) ? r_good : sum_raw;
        mag_use  = sum_use[SUMW-1] ? SUMW'(-sum_use) : sum_use;
        // keep only sums strictly inside the limit
        n_good   = (mag_use < SUMW'(lim2)) ? sum_use : r_good;
        n_prev_e = ERRW'(sum_use) - ERRW'({r_cfg.target_column, 1'b0});
        acc_wide = (ACCW+1)'(r_acc) + (ACCW+1)'(n_prev_e);
        if (acc_wide[ACCW] != acc_wide[ACCW-1]) begin
            n_acc = acc_wide[ACCW] ? ACC_MIN : ACC_MAX;
        end else begin
            n_acc = acc_wide[ACCW-1:0];
        end
        n_diff   = DIFW'(n_prev_e) - DIFW'(r_prev_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good   <= '0;
            r_prev_e <= '0;
            r_acc    <= '0;
        end else if (upd) begin
            r_good   <= n_good;
            r_prev_e <= n_prev_e;
            r_acc    <= n_acc;
        end
    end

    logic signed [SUMW-1:0] r2_sum;
    logic signed [ERRW-1:0] r2_err;
    logic signed [DIFW-1:0] r2_diff;
    logic signed [ACCW-1:0] r2_acc;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_sum  <= sum_use;
            r2_err  <= n_prev_e;
            r2_diff <= n_diff;
            r2_acc  <= n_acc;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: gain products
    // ------------------------------------------------------------------
    t_prod                  prod;
    logic signed [SUMW-1:0] r3_sum;

    lsp_mult u_mult (
        .i_clk  (i_clk),
        .i_en   (en3),
        .i_cfg  (r_cfg),
        .i_acc  (r2_acc),
        .i_err  (r2_err),
        .i_diff (r2_diff),
        .o_prod (prod)
    );

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_sum <= r2_sum;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: integrator overload check and first partial sums
    // ------------------------------------------------------------------
    logic signed [63:0]     r4_a, r4_b;
    logic                   r4_sat, r4_sat_hi;
    logic signed [SUMW-1:0] r4_sum;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_sat    <= (prod.ph >= IP_LIM) || (prod.ph <= -IP_LIM);
            // integral term below zero drives the turn rate to its top
            r4_sat_hi <= prod.ph[PHW-1];
            r4_a      <= {prod.ph[43:0], {ALW{1'b0}}} + 64'(prod.pl);
            r4_b      <= 64'(prod.pe) + 64'(prod.pd) + 64'sd32768;
            r4_sum    <= r3_sum;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: total and rounding shift (floor after adding one half)
    // ------------------------------------------------------------------
    logic signed [63:0]     total;
    logic signed [QW-1:0]   r5_q;
    logic                   r5_sat, r5_sat_hi;
    logic signed [SUMW-1:0] r5_sum;

    assign total = r4_a + r4_b;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_q      <= total[63:16];
            r5_sat    <= r4_sat;
            r5_sat_hi <= r4_sat_hi;
            r5_sum    <= r4_sum;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: negate, saturate, result register
    // ------------------------------------------------------------------
    logic signed [QW:0]      neg_q;
    logic signed [TURNW-1:0] n_turn;
    logic signed [TURNW-1:0] r_turn;
    logic signed [SUMW-1:0]  r_hsum;

    always_comb begin
        neg_q = -((QW+1)'(r5_q));
        if (r5_sat) begin
            n_turn = r5_sat_hi ? TURN_MAX : TURN_MIN;
        end else if (neg_q > (QW+1)'(TURN_MAX)) begin
            n_turn = TURN_MAX;
        end else if (neg_q < (QW+1)'(TURN_MIN)) begin
            n_turn = TURN_MIN;
        end else begin
            n_turn = neg_q[TURNW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_turn <= n_turn;
            r_hsum <= r5_sum;
        end
    end

    assign m_axis_tvalid = r_v6;
    assign m_axis_tdata  = {7'b0, r_hsum, r_turn};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_in_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted transfer did not reach stage 1");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_v6))
        else $error("input stalled while a stage is empty");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !upd |=> ($stable(r_acc) && $stable(r_prev_e) && $stable(r_good)))
        else $error("PID state changed without an item");

    a_sat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r5_sat && en6) |=>
        (m_axis_tdata[31:0] == TURN_MAX || m_axis_tdata[31:0] == TURN_MIN))
        else $error("integrator overload gave an unsaturated turn rate");

endmodule
